@@ rtl/m4i_pkg.sv @@
// Package: widths, tables, types and helpers for the 4x4 matrix inverse block.
package m4i_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int LANES       = 4;
  localparam int NELEM       = 16;
  localparam int NMINOR      = 12;
  localparam int MIN_W       = 2 * DATA_W + 1;
  localparam int OPD_W       = DATA_W + 1;
  localparam int PROD_W      = 2 * OPD_W;
  localparam int COF_W       = DATA_W + MIN_W + 3;
  localparam int DET_W       = 2 * MIN_W + 4;
  localparam int ACC_W       = DET_W;
  localparam int QT_W        = DATA_W + 3;
  localparam int QCNT_W      = $clog2(QT_W);
  localparam int REM_W       = COF_W + 2 * FRAC_BITS + 1;
  localparam int DS_W        = DET_W + QT_W - 1;
  localparam int IN_DATA_W   = 4 * DATA_W;
  localparam int OUT_FLD_W   = 5 * DATA_W + 2;
  localparam int OUT_DATA_W  = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int STEP_W      = 3;
  localparam int ISSUE_STEPS = 6;
  localparam int STEP_LAST   = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MINOR,
    ST_DET,
    ST_COF,
    ST_DSTART,
    ST_DIV
  } state_t;

  typedef enum logic [1:0] {
    KIND_MINOR,
    KIND_DET,
    KIND_COF
  } kind_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_32,
    SH_64
  } sh_t;

  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic       neg;
    sh_t        sh;
    kind_t      kind;
    logic [3:0] dest;
  } mac_op_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [3:0] dest;
  } mac_res_t;

  // minor k = E[a]*E[b] - E[c]*E[d]
  localparam logic [3:0] MINOR_TAB [NMINOR][4] = '{
    '{4'd0, 4'd5, 4'd4, 4'd1},    '{4'd0, 4'd6, 4'd4, 4'd2},
    '{4'd0, 4'd7, 4'd4, 4'd3},    '{4'd1, 4'd6, 4'd5, 4'd2},
    '{4'd1, 4'd7, 4'd5, 4'd3},    '{4'd2, 4'd7, 4'd6, 4'd3},
    '{4'd8, 4'd13, 4'd12, 4'd9},  '{4'd8, 4'd14, 4'd12, 4'd10},
    '{4'd8, 4'd15, 4'd12, 4'd11}, '{4'd9, 4'd14, 4'd13, 4'd10},
    '{4'd9, 4'd15, 4'd13, 4'd11}, '{4'd10, 4'd15, 4'd14, 4'd11}
  };

  // determinant terms: M[a]*M[b], negated where flagged
  localparam logic [3:0] DET_MA  [ISSUE_STEPS] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd4};
  localparam logic [3:0] DET_MB  [ISSUE_STEPS] = '{4'd11, 4'd10, 4'd9, 4'd8, 4'd6, 4'd7};
  localparam logic       DET_NEG [ISSUE_STEPS] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

  // cofactor: {neg, e0, m0, e1, m1, e2, m2}
  localparam logic [3:0] COF_TAB [NELEM][7] = '{
    '{4'd0, 4'd5, 4'd11, 4'd7, 4'd9, 4'd6, 4'd10},
    '{4'd1, 4'd1, 4'd11, 4'd2, 4'd10, 4'd3, 4'd9},
    '{4'd0, 4'd13, 4'd5, 4'd15, 4'd3, 4'd14, 4'd4},
    '{4'd1, 4'd9, 4'd5, 4'd10, 4'd4, 4'd11, 4'd3},
    '{4'd1, 4'd4, 4'd11, 4'd6, 4'd8, 4'd7, 4'd7},
    '{4'd0, 4'd0, 4'd11, 4'd3, 4'd7, 4'd2, 4'd8},
    '{4'd1, 4'd12, 4'd5, 4'd14, 4'd2, 4'd15, 4'd1},
    '{4'd0, 4'd8, 4'd5, 4'd11, 4'd1, 4'd10, 4'd2},
    '{4'd0, 4'd4, 4'd10, 4'd7, 4'd6, 4'd5, 4'd8},
    '{4'd1, 4'd0, 4'd10, 4'd1, 4'd8, 4'd3, 4'd6},
    '{4'd0, 4'd12, 4'd4, 4'd15, 4'd0, 4'd13, 4'd2},
    '{4'd1, 4'd8, 4'd4, 4'd9, 4'd2, 4'd11, 4'd0},
    '{4'd1, 4'd4, 4'd9, 4'd5, 4'd7, 4'd6, 4'd6},
    '{4'd0, 4'd0, 4'd9, 4'd2, 4'd6, 4'd1, 4'd7},
    '{4'd1, 4'd12, 4'd3, 4'd13, 4'd1, 4'd14, 4'd0},
    '{4'd0, 4'd8, 4'd3, 4'd10, 4'd0, 4'd9, 4'd1}
  };

  function automatic logic signed [OPD_W-1:0] sx(input logic [DATA_W-1:0] e);
    return {e[DATA_W-1], e};
  endfunction

  function automatic logic signed [OPD_W-1:0] min_hi(input logic [MIN_W-1:0] m);
    return m[MIN_W-1:DATA_W];
  endfunction

  function automatic logic signed [OPD_W-1:0] min_lo(input logic [MIN_W-1:0] m);
    return {1'b0, m[DATA_W-1:0]};
  endfunction

endpackage

@@ rtl/m4i_mac_lane.sv @@
// One multiply-accumulate lane: registered 33x33 product, shifted accumulate.
module m4i_mac_lane
  import m4i_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_op_t                 op_i,
  input  logic signed [OPD_W-1:0] a_i,
  input  logic signed [OPD_W-1:0] b_i,
  output logic signed [ACC_W-1:0] acc_o,
  output mac_res_t                res_o
);

  mac_op_t                  op1_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  ext;
  logic signed [ACC_W-1:0]  term;
  mac_res_t                 res_r;
  mac_res_t                 res_nxt;

  assign prod_nxt = a_i * b_i;

  always_comb begin
    ext = ACC_W'(prod_r);
    case (op1_r.sh)
      SH_0:    term = ext;
      SH_32:   term = ext <<< 32;
      SH_64:   term = ext <<< 64;
      default: term = ext;
    endcase
    if (op1_r.neg) begin
      term = -term;
    end
    acc_nxt = acc_r;
    if (op1_r.valid) begin
      acc_nxt = (op1_r.first ? '0 : acc_r) + term;
    end
    res_nxt.valid = op1_r.valid & op1_r.last;
    res_nxt.kind  = op1_r.kind;
    res_nxt.dest  = op1_r.dest;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op1_r <= '0;
      res_r <= '0;
    end else begin
      op1_r <= op_i;
      res_r <= res_nxt;
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc_o = acc_r;
  assign res_o = res_r;

endmodule

@@ rtl/m4i_div_lane.sv @@
// One divider lane: restoring division of a cofactor by the determinant, round, saturate.
module m4i_div_lane
  import m4i_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start_i,
  input  logic signed [COF_W-1:0] num_i,
  input  logic signed [DET_W-1:0] den_i,
  output logic                    busy_o,
  output logic [DATA_W-1:0]       quot_o
);

  logic              busy_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [REM_W-1:0]  rem_nxt;
  logic [DS_W-1:0]   ds_r;
  logic [QT_W-1:0]   t_r;
  logic [QT_W-1:0]   t_nxt;
  logic              neg_r;
  logic [DATA_W-1:0] quot_r;
  logic [DATA_W-1:0] quot_nxt;
  logic [COF_W-1:0]  nabs;
  logic [DET_W-1:0]  dabs;
  logic              ge;
  logic [QT_W:0]     qsum;
  logic [QT_W-1:0]   qrnd;

  always_comb begin
    nabs     = num_i[COF_W-1] ? COF_W'(-num_i) : COF_W'(num_i);
    dabs     = den_i[DET_W-1] ? DET_W'(-den_i) : DET_W'(den_i);
    ge       = DS_W'(rem_r) >= ds_r;
    rem_nxt  = ge ? rem_r - ds_r[REM_W-1:0] : rem_r;
    t_nxt    = {t_r[QT_W-2:0], ge};
    qsum     = (QT_W+1)'(t_nxt) + (QT_W+1)'(1);
    qrnd     = qsum[QT_W:1];
    if (neg_r) begin
      if (qrnd > QT_W'(64'h8000_0000)) begin
        quot_nxt = 32'h8000_0000;
      end else begin
        quot_nxt = DATA_W'(0) - qrnd[DATA_W-1:0];
      end
    end else begin
      if (qrnd > QT_W'(64'h7FFF_FFFF)) begin
        quot_nxt = 32'h7FFF_FFFF;
      end else begin
        quot_nxt = qrnd[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= QCNT_W'(QT_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - QCNT_W'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
    if (start_i) begin
      neg_r <= num_i[COF_W-1] ^ den_i[DET_W-1];
      rem_r <= REM_W'(nabs) << (2 * FRAC_BITS + 1);
      ds_r  <= DS_W'(dabs) << (QT_W - 1);
      t_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      ds_r  <= ds_r >> 1;
      t_r   <= t_nxt;
      if (cnt_r == '0) begin
        quot_r <= quot_nxt;
      end
    end
  end

  assign busy_o = busy_r;
  assign quot_o = quot_r;

endmodule

@@ rtl/m4i_merge.sv @@
// Merge stage: sums the lane partial determinants, rounds and saturates det_value.
module m4i_merge
  import m4i_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    trig_i,
  input  logic signed [ACC_W-1:0] acc_i [LANES],
  output logic signed [DET_W-1:0] det_o,
  output logic [DATA_W-1:0]       det_value_o,
  output logic                    singular_o
);

  localparam int DQ_W = DET_W + 1 - 3 * FRAC_BITS;

  logic                    v1_r;
  logic                    v2_r;
  logic signed [ACC_W-1:0] s01_r;
  logic signed [ACC_W-1:0] s23_r;
  logic signed [DET_W-1:0] det_r;
  logic [DATA_W-1:0]       detv_r;
  logic [DATA_W-1:0]       detv_nxt;
  logic                    sing_r;
  logic [DET_W-1:0]        mag;
  logic [DET_W:0]          rnd;
  logic [DQ_W-1:0]         q;

  always_comb begin
    mag = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
    rnd = (DET_W+1)'(mag) + ((DET_W+1)'(1) << (3 * FRAC_BITS - 1));
    q   = rnd[DET_W:3*FRAC_BITS];
    if (det_r[DET_W-1]) begin
      if (q > DQ_W'(64'h8000_0000)) begin
        detv_nxt = 32'h8000_0000;
      end else begin
        detv_nxt = DATA_W'(0) - q[DATA_W-1:0];
      end
    end else begin
      if (q > DQ_W'(64'h7FFF_FFFF)) begin
        detv_nxt = 32'h7FFF_FFFF;
      end else begin
        detv_nxt = q[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= trig_i;
      v2_r <= v1_r;
    end
    if (trig_i) begin
      s01_r <= acc_i[0] + acc_i[1];
      s23_r <= acc_i[2] + acc_i[3];
    end
    if (v1_r) begin
      det_r <= DET_W'(s01_r + s23_r);
    end
    if (v2_r) begin
      detv_r <= detv_nxt;
      sing_r <= (det_r == '0);
    end
  end

  assign det_o       = det_r;
  assign det_value_o = detv_r;
  assign singular_o  = sing_r;

endmodule

@@ rtl/matrix4_inverse_determinant.sv @@
// Top level: 4x4 fixed-point matrix inverse and determinant by cofactors.
//
// Input channel in_*: one matrix row per item, elements in columns 0..3.
// Four items make a matrix; after the fourth the block emits four items on
// out_*, one inverse row each, with the determinant and the singular flag.
// out_tlast marks the fourth result row.
// Sequence per matrix after the fourth row: 2x2 minors, determinant
// products, then cofactor products on four MAC lanes, then per output row a
// division in four parallel divider lanes of 35 quotient bits each.
// Rows of the next matrix are accepted while the current one is being
// divided; its fourth row waits until all four results of the current
// matrix are in the output register.
// A stalled receiver holds the output register; division of the next row
// completes but waits there.
// Reset clears the row count and the sequencer; no results are pending.
module matrix4_inverse_determinant
  import m4i_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // elem_0, elem_1, elem_2, elem_3
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // inv_0..inv_3, row_number, det_value, pad
  output logic [0:0]            out_tuser,  // singular
  output logic                  out_tlast
);

  state_t                  state_r;
  state_t                  state_nxt;
  logic [STEP_W-1:0]       step_r;
  logic [1:0]              row_r;
  logic [1:0]              rows_loaded_r;
  logic [DATA_W-1:0]       elem_r [NELEM];
  logic [MIN_W-1:0]        min_r [NMINOR];
  logic signed [COF_W-1:0] cof_r [NELEM];

  mac_op_t                 lane_op [LANES];
  logic signed [OPD_W-1:0] lane_a [LANES];
  logic signed [OPD_W-1:0] lane_b [LANES];
  logic signed [ACC_W-1:0] lane_acc [LANES];
  mac_res_t                lane_res [LANES];
  logic                    div_busy [LANES];
  logic [DATA_W-1:0]       div_quot [LANES];

  logic signed [DET_W-1:0] det;
  logic [DATA_W-1:0]       det_value;
  logic                    singular;

  logic                    issue;
  logic                    div_start;
  logic                    out_load;
  logic                    in_acc;
  logic                    step_end;

  logic                    out_tvalid_r;
  logic [DATA_W-1:0]       inv_r [LANES];
  logic [1:0]              row_num_r;
  logic [DATA_W-1:0]       det_value_r;
  logic                    singular_r;
  logic                    last_r;

  assign step_end = (step_r == STEP_W'(STEP_LAST));
  assign in_acc   = in_tvalid & in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc && rows_loaded_r == 2'd3) state_nxt = ST_MINOR;
      ST_MINOR:  if (step_end) state_nxt = ST_DET;
      ST_DET:    if (step_end) state_nxt = ST_COF;
      ST_COF:    if (step_end && row_r == 2'd3) state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DIV;
      ST_DIV:    if (out_load) state_nxt = (row_r == 2'd3) ? ST_IDLE : ST_DSTART;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    issue     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_MINOR, ST_DET, ST_COF: begin
        issue = (step_r < STEP_W'(ISSUE_STEPS));
      end
      ST_DSTART: begin
        div_start = 1'b1;
        in_tready = (rows_loaded_r != 2'd3);
      end
      ST_DIV: begin
        out_load  = !div_busy[0] && (!out_tvalid_r || out_tready);
        in_tready = (rows_loaded_r != 2'd3);
      end
      default: ;
    endcase
  end

  // lane operand selection
  always_comb begin
    logic [3:0] k;
    logic [3:0] ci;
    logic [3:0] ei;
    logic [3:0] mi;
    logic       ng;
    for (int l = 0; l < LANES; l++) begin
      lane_op[l]       = '0;
      lane_a[l]        = '0;
      lane_b[l]        = '0;
      ei               = '0;
      mi               = '0;
      ng               = 1'b0;
      k                = {step_r[2:1], 2'(l)};
      ci               = {row_r, 2'(l)};
      lane_op[l].valid = issue;
      case (state_r)
        ST_MINOR: begin
          lane_op[l].kind = KIND_MINOR;
          lane_op[l].dest = k;
          lane_op[l].sh   = SH_0;
          lane_op[l].neg  = step_r[0];
          lane_op[l].first = !step_r[0];
          lane_op[l].last  = step_r[0];
          if (step_r[0]) begin
            lane_a[l] = sx(elem_r[MINOR_TAB[k][2]]);
            lane_b[l] = sx(elem_r[MINOR_TAB[k][3]]);
          end else begin
            lane_a[l] = sx(elem_r[MINOR_TAB[k][0]]);
            lane_b[l] = sx(elem_r[MINOR_TAB[k][1]]);
          end
        end
        ST_DET: begin
          lane_op[l].kind  = KIND_DET;
          lane_op[l].dest  = '0;
          lane_op[l].neg   = DET_NEG[step_r];
          lane_op[l].first = (step_r == '0);
          lane_op[l].last  = (step_r == STEP_W'(ISSUE_STEPS - 1));
          case (l)
            0: begin
              lane_op[l].sh = SH_64;
              lane_a[l] = min_hi(min_r[DET_MA[step_r]]);
              lane_b[l] = min_hi(min_r[DET_MB[step_r]]);
            end
            1: begin
              lane_op[l].sh = SH_32;
              lane_a[l] = min_hi(min_r[DET_MA[step_r]]);
              lane_b[l] = min_lo(min_r[DET_MB[step_r]]);
            end
            2: begin
              lane_op[l].sh = SH_32;
              lane_a[l] = min_lo(min_r[DET_MA[step_r]]);
              lane_b[l] = min_hi(min_r[DET_MB[step_r]]);
            end
            default: begin
              lane_op[l].sh = SH_0;
              lane_a[l] = min_lo(min_r[DET_MA[step_r]]);
              lane_b[l] = min_lo(min_r[DET_MB[step_r]]);
            end
          endcase
        end
        ST_COF: begin
          case (step_r[2:1])
            2'd0: begin
              ei = COF_TAB[ci][1];
              mi = COF_TAB[ci][2];
              ng = COF_TAB[ci][0][0];
            end
            2'd1: begin
              ei = COF_TAB[ci][3];
              mi = COF_TAB[ci][4];
              ng = 1'b0;
            end
            default: begin
              ei = COF_TAB[ci][5];
              mi = COF_TAB[ci][6];
              ng = 1'b1;
            end
          endcase
          lane_op[l].kind  = KIND_COF;
          lane_op[l].dest  = ci;
          lane_op[l].neg   = ng;
          lane_op[l].first = (step_r == '0);
          lane_op[l].last  = (step_r == STEP_W'(ISSUE_STEPS - 1));
          lane_op[l].sh    = step_r[0] ? SH_0 : SH_32;
          lane_a[l]        = sx(elem_r[ei]);
          lane_b[l]        = step_r[0] ? min_lo(min_r[mi]) : min_hi(min_r[mi]);
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    m4i_mac_lane u_mac (
      .clk   (clk),
      .rst_n (rst_n),
      .op_i  (lane_op[g]),
      .a_i   (lane_a[g]),
      .b_i   (lane_b[g]),
      .acc_o (lane_acc[g]),
      .res_o (lane_res[g])
    );

    m4i_div_lane u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .start_i (div_start),
      .num_i   (cof_r[{row_r, 2'(g)}]),
      .den_i   (det),
      .busy_o  (div_busy[g]),
      .quot_o  (div_quot[g])
    );
  end

  m4i_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .trig_i      (lane_res[0].valid && lane_res[0].kind == KIND_DET),
    .acc_i       (lane_acc),
    .det_o       (det),
    .det_value_o (det_value),
    .singular_o  (singular)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      step_r        <= '0;
      row_r         <= '0;
      rows_loaded_r <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_MINOR || state_r == ST_DET || state_r == ST_COF) begin
        step_r <= step_r + STEP_W'(1);
      end else begin
        step_r <= '0;
      end
      if ((state_r == ST_COF && step_end) || out_load) begin
        row_r <= row_r + 2'd1;
      end
      if (in_acc) begin
        rows_loaded_r <= rows_loaded_r + 2'd1;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      for (int i = 0; i < 4; i++) begin
        elem_r[{rows_loaded_r, 2'(i)}] <= in_tdata[i*DATA_W +: DATA_W];
      end
    end
    for (int l = 0; l < LANES; l++) begin
      if (lane_res[l].valid) begin
        case (lane_res[l].kind)
          KIND_MINOR: min_r[lane_res[l].dest] <= lane_acc[l][MIN_W-1:0];
          KIND_COF:   cof_r[lane_res[l].dest] <= lane_acc[l][COF_W-1:0];
          default: ;
        endcase
      end
    end
    if (out_load) begin
      for (int l = 0; l < LANES; l++) begin
        inv_r[l] <= singular ? '0 : div_quot[l];
      end
      row_num_r   <= row_r;
      det_value_r <= singular ? '0 : det_value;
      singular_r  <= singular;
      last_r      <= (row_r == 2'd3);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(OUT_DATA_W - OUT_FLD_W)'(0), det_value_r, row_num_r,
                       inv_r[3], inv_r[2], inv_r[1], inv_r[0]};
  assign out_tuser  = singular_r;
  assign out_tlast  = last_r;

endmodule
